// ===== rtl/core/brr_pkg.sv =====
`timescale 1ns / 1ps

package brr_pkg;

    // Default register geometry.
    localparam int REG_LENGTH_DEF  = 6;
    localparam int WINDOW_BITS_DEF = 3;

    // Shared multiplier operand widths: the wide operand carries the noise seed or a
    // register window, the narrow one the generator multiplier or the gain.
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 21;

    localparam logic [MUL_B_W-1:0] LCG_MUL = 21'd1664525;
    localparam logic [MUL_A_W-1:0] LCG_ADD = 32'd1013904223;

    // Field widths.
    localparam int LEVEL_W = 12;
    localparam int GAIN_W  = 13;
    localparam int MODE_W  = 2;
    localparam int BITS_W  = 6;

    // Entering-bit modes.
    localparam logic [MODE_W-1:0] MODE_FORCE     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NOISE     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TOGGLE    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NOISE_ALT = 2'd3;

    // Threshold dead zones and noise limits.
    localparam logic [LEVEL_W-1:0] THR_LOW    = 12'd15;
    localparam logic [LEVEL_W-1:0] THR_HIGH   = 12'd4080;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 12'd4095;
    localparam logic [LEVEL_W-1:0] NOISE_MIN  = 12'd1;
    localparam logic [LEVEL_W-1:0] NOISE_MAX  = 12'd4094;
    localparam logic [LEVEL_W-1:0] NOISE_BIAS = 12'h800;

endpackage

// ===== rtl/core/bidirectional_rungler_register.sv =====
`timescale 1ns / 1ps

// Channel | Handshake          | Payload
// --------+--------------------+--------------------------------------------------
// input   | in_valid/in_ready  | fwd_edge back_edge mode threshold_level gain_level
//         |                    | offset_level noise_present noise_sample
// output  | out_valid/out_ready| wave_out_a wave_out_b gate_out_a gate_out_b
//         |                    | register_bits
//
// A transaction runs S_WAVE_A, S_WAVE_B and S_DONE; each set edge adds a multiply and an
// update state before them, forward first; every step runs through one shared multiplier.
// Reset clears the shift register and sets the noise seed to one.
// The input is taken only while the sequencer is idle; a finished result waits in
// the output register, and the sequencer holds its last step while that register is full.
module bidirectional_rungler_register #(
    parameter int REG_LENGTH  = brr_pkg::REG_LENGTH_DEF,
    parameter int WINDOW_BITS = brr_pkg::WINDOW_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        fwd_edge,
    input  logic                        back_edge,
    input  logic [brr_pkg::MODE_W-1:0]  mode,
    input  logic [brr_pkg::LEVEL_W-1:0] threshold_level,
    input  logic [brr_pkg::GAIN_W-1:0]  gain_level,
    input  logic [brr_pkg::LEVEL_W-1:0] offset_level,
    input  logic                        noise_present,
    input  logic signed [brr_pkg::LEVEL_W-1:0] noise_sample,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [brr_pkg::LEVEL_W-1:0] wave_out_a,
    output logic signed [brr_pkg::LEVEL_W-1:0] wave_out_b,
    output logic                        gate_out_a,
    output logic                        gate_out_b,
    output logic [brr_pkg::BITS_W-1:0]  register_bits
);

    localparam int LW       = brr_pkg::LEVEL_W;
    localparam int PadW     = REG_LENGTH + 8;
    localparam int HighShift = (REG_LENGTH >= WINDOW_BITS) ? (REG_LENGTH - WINDOW_BITS) : 0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FWD_MUL,
        S_FWD_UPD,
        S_BACK_MUL,
        S_BACK_UPD,
        S_WAVE_A,
        S_WAVE_B,
        S_DONE
    } state_t;

    // Scaled window level plus offset, inverted and clipped to signed 12 bits.
    function automatic logic [LW-1:0] wave_level(input logic [brr_pkg::MUL_A_W-1:0] p,
                                                 input logic [LW-1:0] off);
        logic signed [15:0] s;
        begin
            s = 16'sd2048 - $signed({3'b000, p[24:12]}) - $signed({4'b0000, off});
            if (s < -16'sd2048)
                wave_level = 12'h800;
            else if (s > 16'sd2047)
                wave_level = 12'h7FF;
            else
                wave_level = s[LW-1:0];
        end
    endfunction

    state_t                      state_reg;
    logic [REG_LENGTH-1:0]       shift_bits_reg;
    logic [brr_pkg::MUL_A_W-1:0] noise_seed_reg;

    logic                        back_reg;
    logic [brr_pkg::MODE_W-1:0]  mode_reg;
    logic [LW-1:0]               thr_reg;
    logic [brr_pkg::GAIN_W-1:0]  gain_reg;
    logic [LW-1:0]               offset_reg;
    logic                        ext_reg;
    logic [LW-1:0]               sample_reg;
    logic [LW-1:0]               wave_a_reg;

    logic                        out_valid_reg;
    logic [LW-1:0]               wave_out_a_reg;
    logic [LW-1:0]               wave_out_b_reg;
    logic                        gate_out_a_reg;
    logic                        gate_out_b_reg;
    logic [brr_pkg::BITS_W-1:0]  register_bits_reg;

    logic [brr_pkg::MUL_A_W-1:0] mul_a;
    logic [brr_pkg::MUL_B_W-1:0] mul_b;
    logic [brr_pkg::MUL_A_W-1:0] mul_prod;

    logic [LW-1:0]               thr_in;
    logic [brr_pkg::MODE_W-1:0]  mode_in;
    logic                        back_dir;
    logic [REG_LENGTH-1:0]       r_rot;
    logic                        cur_bit;
    logic [brr_pkg::MUL_A_W-1:0] noise_seed_next;
    logic [LW-1:0]               noise_raw;
    logic [LW-1:0]               noise_val;
    logic                        enter_bit;
    logic [REG_LENGTH-1:0]       r_new;
    logic                        need_lcg;
    logic [PadW-1:0]             bits_pad;
    logic [WINDOW_BITS-1:0]      win_a;
    logic [WINDOW_BITS-1:0]      win_b;
    logic [LW-1:0]               wave_now;
    logic                        out_free;

    brr_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_prod)
    );

    // Input conditioning at acceptance: dead-zoned threshold, mode three folded to noise.
    always_comb
    begin
        if (threshold_level < brr_pkg::THR_LOW)
            thr_in = '0;
        else if (threshold_level > brr_pkg::THR_HIGH)
            thr_in = brr_pkg::LEVEL_MAX;
        else
            thr_in = threshold_level;
        mode_in = (mode == brr_pkg::MODE_NOISE_ALT) ? brr_pkg::MODE_NOISE : mode;
    end

    // Edge update: rotation, noise decision and entering bit.
    always_comb
    begin
        back_dir = (state_reg == S_BACK_UPD);
        if (back_dir)
            r_rot = {shift_bits_reg[0], shift_bits_reg[REG_LENGTH-1:1]};
        else
            r_rot = {shift_bits_reg[REG_LENGTH-2:0], shift_bits_reg[REG_LENGTH-1]};
        cur_bit = back_dir ? r_rot[REG_LENGTH-1] : r_rot[0];

        noise_seed_next = mul_prod + brr_pkg::LCG_ADD;
        noise_raw = ext_reg ? (sample_reg ^ brr_pkg::NOISE_BIAS) : noise_seed_next[31:20];
        if (noise_raw < brr_pkg::NOISE_MIN)
            noise_val = brr_pkg::NOISE_MIN;
        else if (noise_raw > brr_pkg::NOISE_MAX)
            noise_val = brr_pkg::NOISE_MAX;
        else
            noise_val = noise_raw;

        unique case (mode_reg)
            brr_pkg::MODE_FORCE:  enter_bit = !back_dir;
            brr_pkg::MODE_TOGGLE: enter_bit = !cur_bit;
            default:              enter_bit = (noise_val > thr_reg) ? !cur_bit : cur_bit;
        endcase

        if (back_dir)
            r_new = {enter_bit, r_rot[REG_LENGTH-2:0]};
        else
            r_new = {r_rot[REG_LENGTH-1:1], enter_bit};

        need_lcg = (mode_reg == brr_pkg::MODE_NOISE) && !ext_reg;
    end

    // Windows and multiplier operand selection.
    always_comb
    begin
        bits_pad = {{(PadW - REG_LENGTH){1'b0}}, shift_bits_reg};
        win_a    = bits_pad[WINDOW_BITS-1:0];
        win_b    = bits_pad[HighShift +: WINDOW_BITS];
        unique case (state_reg)
            S_FWD_MUL, S_BACK_MUL:
            begin
                mul_a = noise_seed_reg;
                mul_b = brr_pkg::LCG_MUL;
            end
            S_WAVE_A:
            begin
                mul_a = brr_pkg::MUL_A_W'({win_a, {(LW - WINDOW_BITS){1'b0}}});
                mul_b = brr_pkg::MUL_B_W'(gain_reg);
            end
            default:
            begin
                mul_a = brr_pkg::MUL_A_W'({win_b, {(LW - WINDOW_BITS){1'b0}}});
                mul_b = brr_pkg::MUL_B_W'(gain_reg);
            end
        endcase
        wave_now = wave_level(mul_prod, offset_reg);
        out_free = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            shift_bits_reg <= '0;
            noise_seed_reg <= brr_pkg::MUL_A_W'(1);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // In the done state a new result may replace the one leaving.
            if (out_valid_reg && out_ready && (state_reg != S_DONE))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        back_reg   <= back_edge;
                        mode_reg   <= mode_in;
                        thr_reg    <= thr_in;
                        gain_reg   <= gain_level;
                        offset_reg <= offset_level;
                        ext_reg    <= noise_present;
                        sample_reg <= noise_sample;
                        if (fwd_edge)
                            state_reg <= S_FWD_MUL;
                        else if (back_edge)
                            state_reg <= S_BACK_MUL;
                        else
                            state_reg <= S_WAVE_A;
                    end
                end
                S_FWD_MUL:
                    state_reg <= S_FWD_UPD;
                S_FWD_UPD:
                begin
                    shift_bits_reg <= r_new;
                    if (need_lcg)
                        noise_seed_reg <= noise_seed_next;
                    state_reg <= back_reg ? S_BACK_MUL : S_WAVE_A;
                end
                S_BACK_MUL:
                    state_reg <= S_BACK_UPD;
                S_BACK_UPD:
                begin
                    shift_bits_reg <= r_new;
                    if (need_lcg)
                        noise_seed_reg <= noise_seed_next;
                    state_reg <= S_WAVE_A;
                end
                S_WAVE_A:
                    state_reg <= S_WAVE_B;
                S_WAVE_B:
                begin
                    wave_a_reg <= wave_now;
                    state_reg  <= S_DONE;
                end
                S_DONE:
                begin
                    // The multiplier keeps being fed the high window, so the product holds.
                    if (out_free)
                    begin
                        wave_out_a_reg    <= wave_a_reg;
                        wave_out_b_reg    <= wave_now;
                        gate_out_a_reg    <= bits_pad[REG_LENGTH-4];
                        gate_out_b_reg    <= bits_pad[REG_LENGTH-1];
                        register_bits_reg <= bits_pad[brr_pkg::BITS_W-1:0];
                        out_valid_reg     <= 1'b1;
                        state_reg         <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign wave_out_a    = wave_out_a_reg;
    assign wave_out_b    = wave_out_b_reg;
    assign gate_out_a    = gate_out_a_reg;
    assign gate_out_b    = gate_out_b_reg;
    assign register_bits = register_bits_reg;

endmodule

// ===== rtl/core/brr_mul.sv =====
`timescale 1ns / 1ps

// Shared multiplier with a registered product. Only the low word is kept,
// which is all the noise generator and the window scaling need.
module brr_mul (
    input  logic                        clk,
    input  logic [brr_pkg::MUL_A_W-1:0] op_a,
    input  logic [brr_pkg::MUL_B_W-1:0] op_b,
    output logic [brr_pkg::MUL_A_W-1:0] prod
);

    logic [brr_pkg::MUL_A_W-1:0] prod_reg;
    logic [brr_pkg::MUL_A_W-1:0] prod_next;

    assign prod_next = brr_pkg::MUL_A_W'(op_a * {{(brr_pkg::MUL_A_W - brr_pkg::MUL_B_W){1'b0}}, op_b});

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule
